FILE: sv/jad_pkg.sv
package jad_pkg;

  localparam int ANGLE_W    = 16;
  localparam int POS_W      = 13;
  localparam int JIDX_W     = 3;
  localparam int DB_W       = 13;
  localparam int CAL_JOINTS = 5;
  localparam int POS_CENTER = 2048;
  localparam int Q_DEPTH    = 2;

  localparam int X_W     = 28;
  localparam int DEN_W   = 24;
  localparam int SLOPE_W = 11;
  localparam int PROD_W  = DEN_W + SLOPE_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int FRAC_SH = 13;
  localparam int REM_W   = NUM_W - FRAC_SH;
  localparam int QUO_W   = 11;
  localparam int RCP_W   = 25;
  localparam int RCP_SH  = 35;
  localparam int QP_W    = RCP_SH + QUO_W;

  // Reciprocals of the segment spans, rounded up, exact for any REM_W-bit dividend.
  localparam logic [RCP_W-1:0] RCP_1600 = RCP_W'(((64'd1 << RCP_SH) + 64'd1599) / 64'd1600);
  localparam logic [RCP_W-1:0] RCP_1750 = RCP_W'(((64'd1 << RCP_SH) + 64'd1749) / 64'd1750);
  localparam logic [RCP_W-1:0] RCP_2000 = RCP_W'(((64'd1 << RCP_SH) + 64'd1999) / 64'd2000);
  localparam logic [RCP_W-1:0] RCP_3000 = RCP_W'(((64'd1 << RCP_SH) + 64'd2999) / 64'd3000);

  localparam logic [DB_W-1:0] DEADBAND_RST = 13'd8;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [JIDX_W-1:0]         joint;
    logic                      take;
    logic                      last;
  } jad_item_t;

  typedef struct packed {
    logic signed [X_W-1:0] x0_q;
    logic [DEN_W-1:0]      den;
    logic [RCP_W-1:0]      recip;
    logic [POS_W-1:0]      base;
    logic [SLOPE_W-1:0]    slope;
    logic                  desc;
  } jad_seg_t;

  function automatic jad_seg_t seg_make(input int x0_mrad, input int span_mrad,
                                        input logic [RCP_W-1:0] recip,
                                        input int base, input int slope,
                                        input logic desc);
    jad_seg_t s;
    s.x0_q  = X_W'(x0_mrad * 4096);
    s.den   = DEN_W'(span_mrad * 4096);
    s.recip = recip;
    s.base  = POS_W'(base);
    s.slope = SLOPE_W'(slope);
    s.desc  = desc;
    return s;
  endfunction

  // Descending segments are mirrored so the slope stays positive.
  function automatic jad_seg_t cal_seg(input logic [JIDX_W-1:0] joint, input logic upper);
    jad_seg_t s;
    s = seg_make(0, 1600, RCP_1600, POS_CENTER, 0, 1'b0);
    unique case (joint)
      3'd0: s = upper ? seg_make(0, 1600, RCP_1600, 1010, 1055, 1'b1)
                      : seg_make(-1600, 1600, RCP_1600, 2065, 1055, 1'b1);
      3'd1: s = upper ? seg_make(0, 1750, RCP_1750, 929, 1141, 1'b1)
                      : seg_make(-1750, 1750, RCP_1750, 2070, 1141, 1'b1);
      3'd2: s = seg_make(0, 3000, RCP_3000, 92, 1956, 1'b1);
      3'd3: s = upper ? seg_make(0, 1750, RCP_1750, 2048, 1141, 1'b0)
                      : seg_make(-1750, 1750, RCP_1750, 907, 1141, 1'b0);
      3'd4: s = upper ? seg_make(0, 2000, RCP_2000, 2048, 1304, 1'b0)
                      : seg_make(-2000, 2000, RCP_2000, 744, 1304, 1'b0);
      default: s = seg_make(0, 1600, RCP_1600, POS_CENTER, 0, 1'b0);
    endcase
    return s;
  endfunction

endpackage

FILE: sv/jad_front.sv
module jad_front #(
  parameter int JOINTS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [jad_pkg::ANGLE_W-1:0] in_angle_q12,
  input  logic                              in_last_of_command,
  input  logic                              q_full,
  output logic                              q_push,
  output jad_pkg::jad_item_t                q_item
);

  localparam int CW = $clog2(JOINTS + 1);
  localparam logic [CW-1:0] JOINTS_C = CW'(JOINTS);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          take;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign take     = cnt_r < JOINTS_C;

  always_comb begin
    q_item.angle = in_angle_q12;
    q_item.joint = jad_pkg::JIDX_W'(cnt_r);
    q_item.take  = take;
    q_item.last  = in_last_of_command;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_last_of_command) begin
        cnt_nxt = '0;
      end else if (take) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/jad_queue.sv
module jad_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jad_pkg::jad_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output jad_pkg::jad_item_t head
);

  localparam int DEPTH = jad_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_C = FW'(DEPTH);

  jad_pkg::jad_item_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [FW-1:0]      fill_r;

  assign full  = fill_r == DEPTH_C;
  assign valid = fill_r != '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

endmodule

FILE: sv/jad_back.sv
module jad_back #(
  parameter int JOINTS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [jad_pkg::DB_W-1:0]       deadband,
  input  logic                           q_valid,
  input  jad_pkg::jad_item_t             q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jad_pkg::JIDX_W-1:0]     out_joint_index,
  output logic [jad_pkg::POS_W-1:0]      out_servo_position,
  output logic                           out_last_of_burst
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int CW = $clog2(JOINTS + 1);
  localparam logic [CW-1:0] JOINTS_C = CW'(JOINTS);

  localparam int X_W    = jad_pkg::X_W;
  localparam int DEN_W  = jad_pkg::DEN_W;
  localparam int PROD_W = jad_pkg::PROD_W;
  localparam int NUM_W  = jad_pkg::NUM_W;
  localparam int REM_W  = jad_pkg::REM_W;
  localparam int QUO_W  = jad_pkg::QUO_W;
  localparam int QP_W   = jad_pkg::QP_W;
  localparam int RCP_SH = jad_pkg::RCP_SH;
  localparam int POS_W  = jad_pkg::POS_W;

  localparam logic signed [X_W-1:0] ANGLE_SCALE = X_W'(1000);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FILT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  jad_pkg::jad_item_t  item_r, item_nxt;
  jad_pkg::jad_seg_t   seg_r, seg_nxt;
  logic [DEN_W-1:0]    xc_r, xc_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [POS_W-1:0]    stored_r [JOINTS];
  logic [POS_W-1:0]    stored_nxt [JOINTS];
  logic                has_prev_r, has_prev_nxt;
  logic                any_chg_r, any_chg_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [jad_pkg::JIDX_W-1:0] out_joint_r, out_joint_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                out_last_r, out_last_nxt;

  logic                    upper;
  logic signed [X_W-1:0]   ang_x, x_raw, den_x;
  logic [DEN_W-1:0]        xc_c, xx;
  logic [NUM_W-1:0]        num;
  logic [QP_W-1:0]         qprod;
  logic [JW-1:0]           rd_idx;
  logic [POS_W-1:0]        rd_pos, tgt, diff;
  logic                    chg, end_cmd, emit_last;
  logic [CW-1:0]           end_cnt;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  assign upper = !q_item.angle[jad_pkg::ANGLE_W-1] && (q_item.angle != '0);
  assign ang_x = X_W'(item_r.angle);
  assign x_raw = ang_x * ANGLE_SCALE - seg_r.x0_q;
  assign den_x = X_W'(seg_r.den);
  assign xc_c  = x_raw[X_W-1] ? '0 : ((x_raw > den_x) ? seg_r.den : x_raw[DEN_W-1:0]);
  assign xx    = seg_r.desc ? (seg_r.den - xc_r) : xc_r;
  assign num   = {prod_r, 1'b0} + NUM_W'(seg_r.den);
  assign qprod = QP_W'(rem_r) * QP_W'(seg_r.recip);

  assign rd_idx    = (state_r == S_EMIT) ? k_r[JW-1:0] : item_r.joint[JW-1:0];
  assign rd_pos    = stored_r[rd_idx];
  assign tgt       = seg_r.base + POS_W'(quo_r);
  assign diff      = (tgt >= rd_pos) ? (tgt - rd_pos) : (rd_pos - tgt);
  assign emit_last = (k_r + CW'(1)) == cnt_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    seg_nxt       = seg_r;
    xc_nxt        = xc_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    stored_nxt    = stored_r;
    has_prev_nxt  = has_prev_r;
    any_chg_nxt   = any_chg_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_joint_nxt = out_joint_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    chg           = 1'b0;
    end_cmd       = 1'b0;
    end_cnt       = JOINTS_C;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          seg_nxt  = jad_pkg::cal_seg(q_item.joint, upper);
          if (q_item.take) begin
            state_nxt = S_MAP;
          end else if (q_item.last) begin
            end_cmd = 1'b1;
          end
        end
      end
      S_MAP: begin
        xc_nxt    = xc_c;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(xx) * PROD_W'(seg_r.slope);
        state_nxt = S_NORM;
      end
      S_NORM: begin
        rem_nxt   = num[NUM_W-1:jad_pkg::FRAC_SH];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = qprod[QP_W-1:RCP_SH];
        state_nxt = S_FILT;
      end
      S_FILT: begin
        if (!has_prev_r) begin
          stored_nxt[rd_idx] = tgt;
        end else if (diff >= deadband) begin
          stored_nxt[rd_idx] = tgt;
          chg                = 1'b1;
          any_chg_nxt        = 1'b1;
        end
        if (item_r.last) begin
          end_cmd = 1'b1;
          end_cnt = CW'(item_r.joint) + CW'(1);
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_joint_nxt = jad_pkg::JIDX_W'(k_r);
          out_pos_nxt   = rd_pos;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (end_cmd) begin
      has_prev_nxt = 1'b1;
      any_chg_nxt  = 1'b0;
      cnt_nxt      = end_cnt;
      k_nxt        = '0;
      state_nxt    = (any_chg_r || chg || !has_prev_r) ? S_EMIT : S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      has_prev_r  <= 1'b0;
      any_chg_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      k_r         <= '0;
      stored_r    <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      has_prev_r  <= has_prev_nxt;
      any_chg_r   <= any_chg_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      stored_r    <= stored_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    seg_r       <= seg_nxt;
    xc_r        <= xc_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    out_joint_r <= out_joint_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_joint_index    = out_joint_r;
  assign out_servo_position = out_pos_r;
  assign out_last_of_burst  = out_last_r;

endmodule

FILE: sv/joint_angle_to_servo_deadband_unit.sv
// Joint angle to servo position with deadband filtering.
// Input channel (in_valid/in_ready): one Q3.12 joint angle per beat, joints in
// order, in_last_of_command set on the final angle of a command. Beats past
// JOINTS in one command are dropped, but their flag still ends the command.
// Output channel (out_valid/out_ready): at the end of a command that changed
// some joint (or the first command after reset) the stored positions of all
// joints seen in that command go out as a burst, joint 0 first, one beat per
// cycle while out_ready is high, out_last_of_burst on the final beat.
// Each taken angle goes through the back-end steps pop and table lookup, clamp,
// multiply, normalize, a reciprocal multiply for the rounded quotient and the
// deadband update; a dropped beat is popped without them. The back end takes no
// new angle from the queue until the last one has had its deadband update. The
// burst follows the flagged angle's deadband update, each beat registered.
// A two-entry queue sits between the accepting front end and the back end, so
// input beats keep being taken while the back end computes or a burst stalls.
// If the receiver holds out_ready low, the current beat holds and the back end
// waits before the next burst beat; the queue then fills and in_ready drops.
// Reset clears the stored positions to zero, the deadband to 8 and forgets any
// earlier command. cfg_wr_en writes cfg_wr_data into the deadband.
module joint_angle_to_servo_deadband_unit #(
  parameter int JOINTS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [jad_pkg::ANGLE_W-1:0] in_angle_q12,
  input  logic                              in_last_of_command,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [jad_pkg::JIDX_W-1:0]        out_joint_index,
  output logic [jad_pkg::POS_W-1:0]         out_servo_position,
  output logic                              out_last_of_burst,
  input  logic                              cfg_wr_en,
  input  logic [jad_pkg::DB_W-1:0]          cfg_wr_data
);

  logic [jad_pkg::DB_W-1:0] deadband_r;
  logic                     q_full, q_push, q_valid, q_pop;
  jad_pkg::jad_item_t       q_in_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= jad_pkg::DEADBAND_RST;
    end else if (cfg_wr_en) begin
      deadband_r <= cfg_wr_data;
    end
  end

  jad_front #(.JOINTS(JOINTS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_angle_q12       (in_angle_q12),
    .in_last_of_command (in_last_of_command),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_in_item)
  );

  jad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  jad_back #(.JOINTS(JOINTS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .deadband           (deadband_r),
    .q_valid            (q_valid),
    .q_item             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_joint_index    (out_joint_index),
    .out_servo_position (out_servo_position),
    .out_last_of_burst  (out_last_of_burst)
  );

endmodule

FILE: sv/jad_checker.sv
module jad_checker #(
  parameter int JOINTS = 5
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [jad_pkg::JIDX_W-1:0]    out_joint_index,
  input logic [jad_pkg::POS_W-1:0]     out_servo_position,
  input logic                          out_last_of_burst
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_joint_index) &&
      $stable(out_servo_position) && $stable(out_last_of_burst))
    else $error("output beat changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_servo_position <= 13'd4096) && (out_joint_index < JOINTS))
    else $error("output beat out of range");

  a_burst_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_burst |=>
      out_valid && (out_joint_index == $past(out_joint_index) + 3'd1))
    else $error("burst beat missing or out of order");

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_burst |=> !out_valid || (out_joint_index == '0))
    else $error("burst does not start at joint zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a beat pending");

endmodule

bind joint_angle_to_servo_deadband_unit jad_checker #(.JOINTS(JOINTS)) u_jad_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_joint_index    (out_joint_index),
  .out_servo_position (out_servo_position),
  .out_last_of_burst  (out_last_of_burst)
);
